// ----- src/assert_macros.svh -----
// Assertion helpers used by mlbs_dp.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while reset is released.
`define MLBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is never true at a rising edge of clk out of reset.
`define MLBS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/mlbs_pkg.sv -----
`timescale 1ns / 1ps
package mlbs_pkg;

  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_QUERY  = 3'd1;
  localparam logic [2:0] CMD_FILL   = 3'd2;
  localparam logic [2:0] CMD_COUNT  = 3'd3;
  localparam logic [2:0] CMD_WINDOW = 3'd4;

  localparam logic [3:0] SEL_NONE = 4'd1;
  localparam logic [3:0] SEL_ACT  = 4'd2;
  localparam logic [3:0] SEL_SEL  = 4'd4;
  localparam logic [3:0] SEL_DISP = 4'd8;

  localparam logic [2:0] REG_DEFAULT_TYPES = 3'd0;
  localparam logic [2:0] REG_GRID_WIDTH    = 3'd1;
  localparam logic [2:0] REG_GRID_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_WIN_LEFT      = 3'd3;
  localparam logic [2:0] REG_WIN_RIGHT     = 3'd4;
  localparam logic [2:0] REG_WIN_TOP       = 3'd5;
  localparam logic [2:0] REG_WIN_BOTTOM    = 3'd6;

  localparam logic [14:0] COUNT_MAX = 15'h7FFF;
  localparam logic [3:0]  DIV_STEPS = 4'd12;

  typedef struct packed {
    logic cap;
    logic clr_go;
    logic fill_go;
    logic cnt_go;
    logic set_go;
    logic q_rd;
    logic q_ev;
    logic div_step;
    logic win_init;
    logic win_rd;
    logic win_ev;
    logic res_ld;
  } ctl_t;

  typedef struct packed {
    logic       sweep_last;
    logic       div_done;
    logic       win_empty;
    logic       win_last;
    logic       out_free;
    logic [2:0] cmd;
    logic [3:0] code;
  } sts_t;

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

  function automatic logic cell_hit(input logic [3:0] code, input logic [2:0] bits,
                                    input logic inr);
    logic ok;
    ok = (code != 4'd0);
    if (code[1] && !(inr && bits[0])) ok = 1'b0;
    if (code[2] && !(inr && bits[1])) ok = 1'b0;
    if (code[3] && !(inr && bits[2])) ok = 1'b0;
    if (code[0]) ok = 1'b1;
    return ok;
  endfunction

endpackage

// ----- src/mlbs_ctrl.sv -----
`timescale 1ns / 1ps
module mlbs_ctrl import mlbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_SET, S_QRD, S_QEV, S_FILL, S_CNT, S_CNTD,
    S_DIV, S_WINIT, S_WCHK, S_WRD, S_WEV, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_go = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.cap = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority case (sts.cmd)
          CMD_SET:    state_nxt = S_SET;
          CMD_QUERY:  state_nxt = S_QRD;
          CMD_FILL:   state_nxt = sts.code[0] ? S_FIN : S_FILL;
          CMD_COUNT:  state_nxt = (sts.code == SEL_ACT || sts.code == SEL_SEL ||
                                   sts.code == SEL_DISP) ? S_CNT : S_FIN;
          CMD_WINDOW: state_nxt = S_DIV;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_SET: begin
        ctl.set_go = 1'b1;
        state_nxt = S_FIN;
      end
      S_QRD: begin
        ctl.q_rd = 1'b1;
        state_nxt = S_QEV;
      end
      S_QEV: begin
        ctl.q_ev = 1'b1;
        state_nxt = S_FIN;
      end
      S_FILL: begin
        ctl.fill_go = 1'b1;
        if (sts.sweep_last) state_nxt = S_FIN;
      end
      S_CNT: begin
        ctl.cnt_go = 1'b1;
        if (sts.sweep_last) state_nxt = S_CNTD;
      end
      S_CNTD: state_nxt = S_FIN;
      S_DIV: begin
        if (sts.div_done) state_nxt = S_WINIT;
        else ctl.div_step = 1'b1;
      end
      S_WINIT: begin
        ctl.win_init = 1'b1;
        state_nxt = S_WCHK;
      end
      S_WCHK: state_nxt = sts.win_empty ? S_FIN : S_WRD;
      S_WRD: begin
        ctl.win_rd = 1'b1;
        state_nxt = S_WEV;
      end
      S_WEV: begin
        ctl.win_ev = 1'b1;
        state_nxt = sts.win_last ? S_FIN : S_WRD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.res_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/mlbs_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mlbs_dp import mlbs_pkg::*; #(
  parameter int CELLS      = 4096,
  parameter int MAX_OFFSET = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic [2:0]  in_cmd,
  input  logic [11:0] in_cell_index,
  input  logic        in_new_value,
  input  logic [3:0]  in_layer_types,
  input  logic        in_use_default,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_masked,
  output logic [14:0] out_count
);

  localparam int WORDS    = (CELLS + 15) / 16;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int REM_BITS = CELLS % 16;
  localparam logic [15:0] LAST_MASK =
    (REM_BITS == 0) ? 16'hFFFF : 16'((32'd1 << REM_BITS) - 32'd1);
  localparam logic [14:0] CELLS_SAT = (CELLS > 32767) ? 15'h7FFF : 15'(CELLS);
  localparam logic [25:0] CELLS_W  = 26'(CELLS);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic signed [11:0] MO_P = 12'(MAX_OFFSET);
  localparam logic signed [11:0] MO_N = -12'(MAX_OFFSET);

  function automatic logic signed [14:0] clamp_off(input logic signed [7:0] v);
    logic signed [11:0] x;
    x = {{4{v[7]}}, v};
    if (x > MO_P) x = MO_P;
    if (x < MO_N) x = MO_N;
    return {{3{x[11]}}, x};
  endfunction

  logic [3:0]  default_r;
  logic [12:0] width_r, height_r;
  logic signed [7:0] left_r, right_r, top_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= SEL_NONE;
      width_r   <= 13'd64;
      height_r  <= 13'd64;
      left_r    <= '0;
      right_r   <= '0;
      top_r     <= '0;
      bottom_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_TYPES: default_r <= cfg_wdata[3:0];
        REG_GRID_WIDTH:    width_r   <= cfg_wdata;
        REG_GRID_HEIGHT:   height_r  <= cfg_wdata;
        REG_WIN_LEFT:      left_r    <= cfg_wdata[7:0];
        REG_WIN_RIGHT:     right_r   <= cfg_wdata[7:0];
        REG_WIN_TOP:       top_r     <= cfg_wdata[7:0];
        REG_WIN_BOTTOM:    bottom_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [12:0] w_eff;
  assign w_eff = (width_r == 13'd0) ? 13'd1 : width_r;

  logic [2:0]  cmd_r;
  logic [11:0] idx_r;
  logic        val_r;
  logic [3:0]  code_r;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_cell_index;
      val_r  <= in_new_value;
      code_r <= in_use_default ? default_r : in_layer_types;
    end
  end

  logic [11:0] rem_r, quo_r;
  logic [3:0]  div_cnt_r;
  logic [12:0] trial;
  logic        qbit;

  always_comb begin
    trial = {rem_r, quo_r[11]};
    qbit  = (trial >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      rem_r     <= '0;
      quo_r     <= in_cell_index;
      div_cnt_r <= '0;
    end else if (ctl.div_step) begin
      rem_r     <= qbit ? 12'(trial - w_eff) : trial[11:0];
      quo_r     <= {quo_r[10:0], qbit};
      div_cnt_r <= div_cnt_r + 4'd1;
    end
  end

  logic signed [14:0] r_r, r1_r, c_r, c0_r, c1_r;
  logic signed [14:0] ay_s, ax_s;
  assign ay_s = {3'b000, quo_r};
  assign ax_s = {3'b000, rem_r};

  logic ingrid;
  logic [25:0] lin_win;
  always_comb begin
    ingrid = !r_r[14] && (r_r < $signed({2'b00, height_r})) &&
             !c_r[14] && (c_r < $signed({2'b00, w_eff}));
    lin_win = 26'(r_r[12:0]) * 26'(w_eff) + 26'(c_r[12:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.win_init) begin
      r_r  <= ay_s + clamp_off(top_r);
      r1_r <= ay_s + clamp_off(bottom_r);
      c_r  <= ax_s + clamp_off(left_r);
      c0_r <= ax_s + clamp_off(left_r);
      c1_r <= ax_s + clamp_off(right_r);
    end else if (ctl.win_ev) begin
      if (c_r == c1_r) begin
        c_r <= c0_r;
        r_r <= r_r + 15'sd1;
      end else begin
        c_r <= c_r + 15'sd1;
      end
    end
  end

  logic [25:0] lin_r;
  logic        og_r;
  logic [25:0] idx_lin;
  assign idx_lin = 26'(idx_r);

  always_ff @(posedge clk) begin
    if (ctl.q_rd) begin
      lin_r <= idx_lin;
      og_r  <= 1'b0;
    end else if (ctl.win_rd) begin
      lin_r <= lin_win;
      og_r  <= !ingrid;
    end
  end

  logic [AW-1:0] sweep_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (ctl.clr_go || ctl.fill_go || ctl.cnt_go) begin
      sweep_r <= (sweep_r == LAST_WORD) ? '0 : sweep_r + AW'(1);
    end
  end

  logic [AW-1:0] wr_addr, rd_addr;
  logic [2:0]    we_word, we_bit;
  logic [15:0]   wdata;
  logic          idx_inr;

  always_comb begin
    idx_inr = (idx_lin < CELLS_W);
    wr_addr = ctl.set_go ? idx_lin[AW+3:4] : sweep_r;
    wdata   = ctl.clr_go ? 16'h0000 : {16{val_r}};
    for (int k = 0; k < 3; k++) begin
      we_word[k] = ctl.clr_go || (ctl.fill_go && code_r[k+1] && !code_r[0]);
      we_bit[k]  = ctl.set_go && code_r[k+1] && !code_r[0] && idx_inr;
    end
    if (ctl.cnt_go) rd_addr = sweep_r;
    else if (ctl.win_rd) rd_addr = lin_win[AW+3:4];
    else rd_addr = idx_lin[AW+3:4];
  end

  logic [15:0] rd_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_layer
    logic [15:0] mem [WORDS];
    always_ff @(posedge clk) begin
      if (we_word[k]) begin
        mem[wr_addr] <= wdata;
      end else if (we_bit[k]) begin
        mem[wr_addr][idx_r[3:0]] <= val_r;
      end
      rd_q[k] <= mem[rd_addr];
    end
  end

  logic          rdv_r, rd_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= ctl.cnt_go;
    end
    rd_last_r <= (sweep_r == LAST_WORD);
  end

  logic [2:0]  bits;
  logic        hit;
  logic [15:0] cnt_word;
  logic [4:0]  add_v;
  logic [15:0] sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bits[k] = rd_q[k][lin_r[3:0]];
    end
    hit = og_r || cell_hit(code_r, bits, lin_r < CELLS_W);
    if (code_r == SEL_ACT) cnt_word = rd_q[0];
    else if (code_r == SEL_SEL) cnt_word = rd_q[1];
    else cnt_word = rd_q[2];
    if (rd_last_r) cnt_word = cnt_word & LAST_MASK;
    if (ctl.win_ev) add_v = 5'(hit);
    else if (rdv_r) add_v = popcount16(cnt_word);
    else add_v = '0;
  end

  logic [14:0] acc_r;
  logic        q_r;
  assign sum = {1'b0, acc_r} + 16'(add_v);

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      acc_r <= '0;
      q_r   <= 1'b0;
    end else begin
      acc_r <= sum[15] ? COUNT_MAX : sum[14:0];
      if (ctl.q_ev) q_r <= hit;
    end
  end

  logic        out_valid_r;
  logic        out_masked_r;
  logic [14:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.res_ld) begin
      out_masked_r <= q_r;
      out_count_r  <= (cmd_r == CMD_COUNT && code_r == SEL_NONE) ? CELLS_SAT : acc_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_masked = out_masked_r;
  assign out_count  = out_count_r;

  always_comb begin
    sts.sweep_last = (sweep_r == LAST_WORD);
    sts.div_done   = (div_cnt_r == DIV_STEPS);
    sts.win_empty  = (r_r > r1_r) || (c_r > c1_r);
    sts.win_last   = (r_r == r1_r) && (c_r == c1_r);
    sts.out_free   = !out_valid_r || out_ready;
    sts.cmd        = cmd_r;
    sts.code       = code_r;
  end

  `MLBS_NEVER(a_no_overwrite, ctl.res_ld && out_valid_r && !out_ready, "result overwritten")
  `MLBS_ASSERT(a_ev_after_rd, ctl.win_ev |-> $past(ctl.win_rd), "window eval without read")
  `MLBS_ASSERT(a_one_op, $onehot0({ctl.clr_go, ctl.fill_go, ctl.cnt_go, ctl.set_go, ctl.win_rd, ctl.q_rd}), "memory ops overlap")

endmodule

// ----- src/multi_layer_bitmask_store_core.sv -----
`timescale 1ns / 1ps
// Three-layer bit mask store (activation, selection, displayed), one item at a
// time. After reset a clearing pass writes every 16-cell row, during which no
// item is taken. A set writes the chosen layer bits of the cell, and a query
// reads the cell's row and then evaluates the cell. Fill and count-all walk the
// 16-bit rows of the layer memories through one port. A window count first
// splits the index with a one-bit-per-cycle divider (12 steps) and then visits
// each cell of the window through the same read port, reading its row and then
// evaluating it. A new item is taken while the previous result still waits in
// the output register.
module multi_layer_bitmask_store_core import mlbs_pkg::*; #(
  parameter int CELLS      = 4096,
  parameter int MAX_OFFSET = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [11:0] in_cell_index,
  input  logic        in_new_value,
  input  logic [3:0]  in_layer_types,
  input  logic        in_use_default,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_masked,
  output logic [14:0] out_count
);

  ctl_t ctl;
  sts_t sts;

  mlbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  mlbs_dp #(
    .CELLS      (CELLS),
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_cmd),
    .in_cell_index  (in_cell_index),
    .in_new_value   (in_new_value),
    .in_layer_types (in_layer_types),
    .in_use_default (in_use_default),
    .ctl            (ctl),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_masked     (out_masked),
    .out_count      (out_count)
  );

endmodule

// ----- tb/mask_store_checker.sv -----
`timescale 1ns / 1ps
module mask_store_checker import mlbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [11:0] in_cell_index,
  input  logic        in_new_value,
  input  logic [3:0]  in_layer_types,
  input  logic        in_use_default,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_masked,
  input  logic [14:0] out_count,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  localparam int NCELLS = 4096;
  localparam int OFFSET_LIMIT = 64;

  typedef struct {
    logic        masked;
    logic [14:0] count;
  } answer_t;

  bit act_bits [NCELLS];
  bit sel_bits [NCELLS];
  bit disp_bits [NCELLS];
  logic [3:0]  dflt_code;
  logic [12:0] cols;
  logic [12:0] rows;
  int          off_left, off_right, off_top, off_bottom;
  answer_t     expected_answers [$];

  function automatic bit cell_selected(int idx, logic [3:0] code);
    bit inr;
    inr = (idx >= 0) && (idx < NCELLS);
    if (code[0]) return 1'b1;
    if (code[1] && !(inr && act_bits[idx])) return 1'b0;
    if (code[2] && !(inr && sel_bits[idx])) return 1'b0;
    if (code[3] && !(inr && disp_bits[idx])) return 1'b0;
    return code != 4'd0;
  endfunction

  function automatic int clamp_offset(int v);
    if (v > OFFSET_LIMIT) return OFFSET_LIMIT;
    if (v < -OFFSET_LIMIT) return -OFFSET_LIMIT;
    return v;
  endfunction

  function automatic int layer_population(logic [3:0] code);
    int n;
    n = 0;
    for (int i = 0; i < NCELLS; i++) begin
      if (code == SEL_ACT) n += act_bits[i];
      else if (code == SEL_SEL) n += sel_bits[i];
      else n += disp_bits[i];
    end
    return n;
  endfunction

  function automatic int window_population(int idx, logic [3:0] code);
    int w, h, ay, ax, n;
    w = (cols == 0) ? 1 : int'(cols);
    h = int'(rows);
    ay = idx / w;
    ax = idx % w;
    n = 0;
    for (int r = ay + clamp_offset(off_top); r <= ay + clamp_offset(off_bottom); r++) begin
      for (int c = ax + clamp_offset(off_left); c <= ax + clamp_offset(off_right); c++) begin
        if (r < 0 || r >= h || c < 0 || c >= w) n++;
        else if (cell_selected(r * w + c, code)) n++;
      end
    end
    return n;
  endfunction

  function automatic answer_t predict_answer(logic [2:0] cmd, int idx, bit val,
                                             logic [3:0] code);
    answer_t a;
    int n;
    a.masked = 1'b0;
    n = 0;
    case (cmd)
      CMD_SET: begin
        if (!code[0]) begin
          if (code[1]) act_bits[idx] = val;
          if (code[2]) sel_bits[idx] = val;
          if (code[3]) disp_bits[idx] = val;
        end
      end
      CMD_QUERY: a.masked = cell_selected(idx, code);
      CMD_FILL: begin
        if (!code[0]) begin
          for (int i = 0; i < NCELLS; i++) begin
            if (code[1]) act_bits[i] = val;
            if (code[2]) sel_bits[i] = val;
            if (code[3]) disp_bits[i] = val;
          end
        end
      end
      CMD_COUNT: begin
        if (code == SEL_NONE) n = NCELLS;
        else if (code == SEL_ACT || code == SEL_SEL || code == SEL_DISP)
          n = layer_population(code);
      end
      CMD_WINDOW: n = window_population(idx, code);
      default: ;
    endcase
    if (n > int'(COUNT_MAX)) n = int'(COUNT_MAX);
    a.count = 15'(n);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NCELLS; i++) begin
        act_bits[i] = 1'b0;
        sel_bits[i] = 1'b0;
        disp_bits[i] = 1'b0;
      end
      dflt_code = SEL_NONE;
      cols = 13'd64;
      rows = 13'd64;
      off_left = 0;
      off_right = 0;
      off_top = 0;
      off_bottom = 0;
      expected_answers.delete();
      mismatches <= 0;
      pending <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEFAULT_TYPES: dflt_code = cfg_wdata[3:0];
          REG_GRID_WIDTH:    cols = cfg_wdata;
          REG_GRID_HEIGHT:   rows = cfg_wdata;
          REG_WIN_LEFT:      off_left = $signed(cfg_wdata[7:0]);
          REG_WIN_RIGHT:     off_right = $signed(cfg_wdata[7:0]);
          REG_WIN_TOP:       off_top = $signed(cfg_wdata[7:0]);
          REG_WIN_BOTTOM:    off_bottom = $signed(cfg_wdata[7:0]);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.masked = out_masked;
        got.count = out_count;
        results_seen <= results_seen + 1;
        if (expected_answers.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result transfer: masked=%0d count=%0d",
                     got.masked, got.count);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_answers.pop_front();
          if (got.masked !== want.masked || got.count !== want.count) begin
            if (mismatches < 10)
              $display("Result mismatch: expected masked=%0d count=%0d, got masked=%0d count=%0d",
                       want.masked, want.count, got.masked, got.count);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_answers.push_back(predict_answer(in_cmd, int'(in_cell_index), in_new_value,
                                   in_use_default ? dflt_code : in_layer_types));
      pending <= expected_answers.size();
    end
  end

endmodule

// ----- tb/tb_multi_layer_bitmask_store_core.sv -----
`timescale 1ns / 1ps
module tb_multi_layer_bitmask_store_core;
  import mlbs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_cmd;
  logic [11:0] in_cell_index;
  logic        in_new_value;
  logic [3:0]  in_layer_types;
  logic        in_use_default;
  logic        out_valid;
  logic        out_ready;
  logic        out_masked;
  logic [14:0] out_count;
  int          mismatches;
  int          pending;
  int          results_seen;
  int          items_sent;
  int          idle_pct;
  int          stall_pct;
  int          phases_run;

  multi_layer_bitmask_store_core dut (.*);

  mask_store_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_item(logic [2:0] cmd, logic [11:0] idx, logic val,
                           logic [3:0] code, logic dflt);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_cell_index <= idx;
    in_new_value <= val;
    in_layer_types <= code;
    in_use_default <= dflt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || out_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [3:0] dt, logic [12:0] w, logic [12:0] h,
                           logic [7:0] l, logic [7:0] r, logic [7:0] t, logic [7:0] b);
    drain();
    write_reg(REG_DEFAULT_TYPES, 13'(dt));
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_WIN_LEFT, 13'(l));
    write_reg(REG_WIN_RIGHT, 13'(r));
    write_reg(REG_WIN_TOP, 13'(t));
    write_reg(REG_WIN_BOTTOM, 13'(b));
    phases_run++;
  endtask

  task automatic random_items(int n, int idle, int stall);
    int pick;
    logic [2:0] cmd;
    logic [11:0] idx;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) cmd = CMD_SET;
      else if (pick < 65) cmd = CMD_QUERY;
      else if (pick < 69) cmd = CMD_FILL;
      else if (pick < 77) cmd = CMD_COUNT;
      else if (pick < 97) cmd = CMD_WINDOW;
      else cmd = 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 9);
      if (pick < 6) idx = 12'($urandom_range(0, 4095));
      else if (pick < 8) idx = 12'($urandom_range(0, 15));
      else idx = 12'(4095 - $urandom_range(0, 15));
      send_item(cmd, idx, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_SET;
    in_cell_index = '0;
    in_new_value = 1'b0;
    in_layer_types = '0;
    in_use_default = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    phases_run = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item(CMD_SET, 12'd0, 1'b1, SEL_ACT, 1'b0);
    send_item(CMD_SET, 12'd4095, 1'b1, 4'd14, 1'b0);
    send_item(CMD_QUERY, 12'd0, 1'b0, SEL_ACT, 1'b0);
    send_item(CMD_QUERY, 12'd0, 1'b0, 4'd0, 1'b0);
    send_item(CMD_QUERY, 12'd5, 1'b0, SEL_NONE, 1'b0);
    send_item(CMD_QUERY, 12'd5, 1'b0, 4'd0, 1'b1);
    send_item(CMD_QUERY, 12'd4095, 1'b0, 4'd14, 1'b0);
    send_item(CMD_SET, 12'd7, 1'b1, 4'd15, 1'b0);
    send_item(CMD_SET, 12'd8, 1'b1, 4'd0, 1'b0);
    send_item(CMD_FILL, 12'd0, 1'b1, SEL_SEL, 1'b0);
    send_item(CMD_COUNT, 12'd0, 1'b0, SEL_SEL, 1'b0);
    send_item(CMD_COUNT, 12'd0, 1'b0, SEL_ACT, 1'b0);
    send_item(CMD_COUNT, 12'd0, 1'b0, SEL_DISP, 1'b0);
    send_item(CMD_COUNT, 12'd0, 1'b0, SEL_NONE, 1'b0);
    send_item(CMD_COUNT, 12'd0, 1'b0, 4'd6, 1'b0);
    send_item(CMD_WINDOW, 12'd0, 1'b0, SEL_ACT, 1'b0);
    send_item(CMD_WINDOW, 12'd4095, 1'b0, 4'd15, 1'b0);
    send_item(CMD_FILL, 12'd0, 1'b0, SEL_SEL, 1'b0);
    send_item(CMD_FILL, 12'd0, 1'b1, 4'd9, 1'b0);
    send_item(3'd5, 12'hFFF, 1'b1, 4'd15, 1'b1);
    send_item(3'd6, 12'd0, 1'b0, 4'd0, 1'b0);
    send_item(3'd7, 12'hAAA, 1'b1, 4'd10, 1'b0);
    send_item(CMD_COUNT, 12'd0, 1'b0, SEL_DISP, 1'b0);

    configure(4'd2, 13'd64, 13'd64, 8'hFF, 8'h01, 8'hFF, 8'h01);
    random_items(300, 0, 0);
    configure(4'd6, 13'd100, 13'd50, 8'hFE, 8'h02, 8'h00, 8'h03);
    random_items(300, 73, 0);
    configure(4'd14, 13'd1, 13'd4096, 8'h00, 8'h00, 8'hFD, 8'h03);
    random_items(300, 0, 73);
    configure(4'd8, 13'd4096, 13'd1, 8'hFB, 8'h05, 8'hFF, 8'h01);
    random_items(300, 30, 30);
    configure(4'd0, 13'd0, 13'd0, 8'h7F, 8'h80, 8'h00, 8'h01);
    random_items(30, 30, 30);
    configure(4'd15, 13'h1FFF, 13'h1FFF, 8'h80, 8'h7F, 8'h80, 8'h7F);
    send_item(CMD_WINDOW, 12'd2080, 1'b0, SEL_ACT, 1'b0);
    random_items(6, 0, 73);
    configure(4'd1, 13'd16, 13'd16, 8'h02, 8'h01, 8'hC0, 8'h40);
    random_items(20, 73, 73);
    configure(4'd3, 13'd16, 13'd16, 8'hC0, 8'h40, 8'h01, 8'h02);
    random_items(20, 0, 0);

    drain();
    $display("Sent %0d items over %0d register settings, %0d results checked.",
             items_sent, phases_run + 1, results_seen);
    $display("Covered grid edges, empty and clamped windows, and all idle and stall mixes.");
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- multi_layer_bitmask_store_core.f -----
+incdir+src
src/mlbs_pkg.sv
src/mlbs_ctrl.sv
src/mlbs_dp.sv
src/multi_layer_bitmask_store_core.sv
tb/mask_store_checker.sv
tb/tb_multi_layer_bitmask_store_core.sv
